// File: src/bq_pkg.sv
package bq_pkg;

    localparam int CHANNELS  = 2;
    localparam int CHAN_W    = 1;
    localparam int SAMP_W    = 24;
    localparam int COEF_W    = 25;
    localparam int FRAC_BITS = 22;
    localparam int PROD_W    = COEF_W + SAMP_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int Q_W       = ACC_W - FRAC_BITS;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    localparam logic signed [SAMP_W-1:0] SAMP_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
    localparam logic signed [SAMP_W-1:0] SAMP_MIN = {1'b1, {(SAMP_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_NOW   = 3'd0,
        REG_FF_PREV  = 3'd1,
        REG_FF_PREV2 = 3'd2,
        REG_FB_PREV  = 3'd3,
        REG_FB_PREV2 = 3'd4
    } cfg_reg_t;

    typedef logic signed [SAMP_W-1:0] samp_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        samp_t x1;
        samp_t x2;
        samp_t y1;
        samp_t y2;
    } taps_t;

endpackage

// File: src/biquad_iir_filter_df1.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    chan, sample_in
// out       output     out_valid / out_ready  chan_out, sample_out
// cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// One beat per cycle sustained while out is not stalled; an accepted beat passes
// through the input register, then the result register, before out_valid rises.
// The five multiplies and the sum are combinational between the input and
// result registers; delay state of a channel updates as its beat moves to out.
// rst_n clears coefficients to pass-through and all delay state to zero.
// A stalled out holds its beat; the input register still drains into it once free.

module biquad_iir_filter_df1
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bq_pkg::CHAN_W-1:0]         chan,
    input  logic signed [bq_pkg::SAMP_W-1:0]  sample_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bq_pkg::CHAN_W-1:0]         chan_out,
    output logic signed [bq_pkg::SAMP_W-1:0]  sample_out,
    input  logic                              cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]         cfg_data
);

    bq_pkg::coef_t b0_reg;
    bq_pkg::coef_t b1_reg;
    bq_pkg::coef_t b2_reg;
    bq_pkg::coef_t a1_reg;
    bq_pkg::coef_t a2_reg;

    bq_pkg::samp_t x1_reg [bq_pkg::CHANNELS];
    bq_pkg::samp_t x2_reg [bq_pkg::CHANNELS];
    bq_pkg::samp_t y1_reg [bq_pkg::CHANNELS];
    bq_pkg::samp_t y2_reg [bq_pkg::CHANNELS];

    logic                        in_valid_reg;
    logic [bq_pkg::CHAN_W-1:0]   in_chan_reg;
    bq_pkg::samp_t               in_sample_reg;

    logic                        out_valid_reg;
    logic [bq_pkg::CHAN_W-1:0]   out_chan_reg;
    bq_pkg::samp_t               out_sample_reg;

    logic                        out_free;
    logic                        advance;
    logic                        chan_ok;
    bq_pkg::taps_t               taps;
    bq_pkg::prod_t               p0, p1, p2, p3, p4;
    bq_pkg::acc_t                acc;
    bq_pkg::acc_t                acc_rnd;
    logic signed [bq_pkg::Q_W-1:0] q;
    logic                        pos_ovf;
    logic                        neg_ovf;
    bq_pkg::samp_t               y_sat;
    bq_pkg::samp_t               y_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;

    assign out_valid  = out_valid_reg;
    assign chan_out   = out_chan_reg;
    assign sample_out = out_sample_reg;

    assign chan_ok = int'(in_chan_reg) < bq_pkg::CHANNELS;

    always_comb
    begin
        taps = '0;
        for (int c = 0; c < bq_pkg::CHANNELS; c++)
        begin
            if (int'(in_chan_reg) == c)
            begin
                taps.x1 = x1_reg[c];
                taps.x2 = x2_reg[c];
                taps.y1 = y1_reg[c];
                taps.y2 = y2_reg[c];
            end
        end
    end

    assign p0 = b0_reg * in_sample_reg;
    assign p1 = b1_reg * taps.x1;
    assign p2 = b2_reg * taps.x2;
    assign p3 = a1_reg * taps.y1;
    assign p4 = a2_reg * taps.y2;

    assign acc = bq_pkg::ACC_W'(p0) + bq_pkg::ACC_W'(p1) + bq_pkg::ACC_W'(p2)
               - bq_pkg::ACC_W'(p3) - bq_pkg::ACC_W'(p4);
    assign acc_rnd = acc + bq_pkg::ROUND_HALF;
    assign q = acc_rnd[bq_pkg::ACC_W-1:bq_pkg::FRAC_BITS];

    assign pos_ovf = !q[bq_pkg::Q_W-1] && (|q[bq_pkg::Q_W-2:bq_pkg::SAMP_W-1]);
    assign neg_ovf = q[bq_pkg::Q_W-1] && !(&q[bq_pkg::Q_W-2:bq_pkg::SAMP_W-1]);

    always_comb
    begin
        if (pos_ovf)
        begin
            y_sat = bq_pkg::SAMP_MAX;
        end
        else if (neg_ovf)
        begin
            y_sat = bq_pkg::SAMP_MIN;
        end
        else
        begin
            y_sat = q[bq_pkg::SAMP_W-1:0];
        end
    end

    assign y_next = chan_ok ? y_sat : '0;

    // coefficient writes; out-of-list index drops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= bq_pkg::COEF_ONE;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bq_pkg::REG_FF_NOW:   b0_reg <= cfg_data;
                bq_pkg::REG_FF_PREV:  b1_reg <= cfg_data;
                bq_pkg::REG_FF_PREV2: b2_reg <= cfg_data;
                bq_pkg::REG_FB_PREV:  a1_reg <= cfg_data;
                bq_pkg::REG_FB_PREV2: a2_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // advance delay lines of the channel whose beat moves to out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < bq_pkg::CHANNELS; c++)
            begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < bq_pkg::CHANNELS; c++)
            begin
                if (advance && int'(in_chan_reg) == c)
                begin
                    x2_reg[c] <= x1_reg[c];
                    x1_reg[c] <= in_sample_reg;
                    y2_reg[c] <= y1_reg[c];
                    y1_reg[c] <= y_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_chan_reg   <= chan;
            in_sample_reg <= sample_in;
        end
        if (advance)
        begin
            out_chan_reg   <= in_chan_reg;
            out_sample_reg <= y_next;
        end
    end

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_advance_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && sample_out == $past(y_next)
                    && chan_out == $past(in_chan_reg))
        else $error("result register missed an advancing beat");

    a_bad_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !chan_ok) |=> sample_out == '0)
        else $error("out-of-range channel gave nonzero sample");

    a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input stage did not drain into free result register");

endmodule
